### rtl/urif_pkg.sv
// Shared types, sizes and helpers for the unique random index filter.
// No dependencies; every other file in rtl/ uses this package.
package urif_pkg;

  localparam int MAX_ITEMS   = 65536;
  localparam int WORD_W      = 30;
  localparam int CNT_W       = 17;
  localparam int OUT_W       = 16;
  localparam int IDX_W       = $clog2(MAX_ITEMS);
  localparam int ROW_W       = 32;
  localparam int ROW_BITS    = $clog2(ROW_W);
  localparam int ROWS        = MAX_ITEMS / ROW_W;
  localparam int ROW_AW      = $clog2(ROWS);
  localparam int DIV_CW      = $clog2(WORD_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0] ITEM_COUNT_RESET = CNT_W'(MAX_ITEMS);

  typedef enum logic {
    ITEM_OFFER,
    ITEM_RESTART
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [WORD_W-1:0] word;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CHECK
  } back_state_t;

  // Size register as the datapath sees it: zero acts as one, over-range saturates.
  function automatic logic [CNT_W-1:0] effective_size(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] res;
    if (cnt == '0) begin
      res = CNT_W'(1);
    end else if (cnt > CNT_W'(MAX_ITEMS)) begin
      res = CNT_W'(MAX_ITEMS);
    end else begin
      res = cnt;
    end
    return res;
  endfunction

endpackage

### rtl/urif_front.sv
// Front end: input register, sorts each transfer into offer or restart.
// Depends on urif_pkg; feeds urif_queue.
module urif_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [urif_pkg::WORD_W-1:0]  in_random_word,
  input  urif_pkg::back_status_t       status,
  input  logic                         q_full,
  output logic                         q_push,
  output urif_pkg::item_t              q_push_item
);

  logic            fr_valid_r;
  urif_pkg::item_t fr_item_r;
  logic            accept;

  assign q_push      = fr_valid_r && !q_full;
  assign q_push_item = fr_item_r;
  // no intake while the bitmap is being swept
  assign in_stall    = status.clearing || (fr_valid_r && q_full);
  assign accept      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (accept) begin
      fr_valid_r <= 1'b1;
    end else if (q_push) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r.kind <= in_command ? urif_pkg::ITEM_RESTART : urif_pkg::ITEM_OFFER;
      fr_item_r.word <= in_random_word;
    end
  end

endmodule

### rtl/urif_queue.sv
// Short FIFO between front end and back end.
// Depends on urif_pkg.
module urif_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  urif_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output urif_pkg::item_t item
);

  urif_pkg::item_t                  entries_r [urif_pkg::QUEUE_DEPTH];
  logic [urif_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [urif_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [urif_pkg::QCNT_W-1:0]      count_r;
  logic                             do_push;
  logic                             do_pop;

  assign full    = (count_r == urif_pkg::QCNT_W'(urif_pkg::QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign item    = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + urif_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + urif_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + urif_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - urif_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/urif_back.sv
// Back end: bit-serial modulo, bitmap read-modify-write, clearing sweep, result register.
// Depends on urif_pkg; fed by urif_queue.
module urif_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [urif_pkg::CNT_W-1:0]  item_count,
  input  logic                        q_valid,
  input  urif_pkg::item_t             q_item,
  output logic                        q_pop,
  output urif_pkg::back_status_t      status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [urif_pkg::OUT_W-1:0]  out_index_value,
  output logic [urif_pkg::OUT_W-1:0]  out_position,
  output logic                        out_last
);

  urif_pkg::back_state_t state_r, state_nxt;

  logic [urif_pkg::ROW_W-1:0]  map_mem [urif_pkg::ROWS];
  logic [urif_pkg::ROW_W-1:0]  rd_data_r;
  logic [urif_pkg::ROW_AW-1:0] row_cnt_r;
  logic [urif_pkg::CNT_W-1:0]  filled_r;
  logic [urif_pkg::IDX_W-1:0]  rem_r;
  logic [urif_pkg::WORD_W-1:0] div_word_r;
  logic [urif_pkg::DIV_CW-1:0] div_cnt_r;

  logic                        out_valid_r;
  logic [urif_pkg::OUT_W-1:0]  out_index_r;
  logic [urif_pkg::OUT_W-1:0]  out_position_r;
  logic                        out_last_r;

  logic [urif_pkg::CNT_W-1:0]  n_eff;
  logic [urif_pkg::IDX_W:0]    rem_sh;
  logic [urif_pkg::IDX_W:0]    rem_diff;
  logic                        rem_ge;
  logic                        start_div, start_clear, emit, hit, out_free, mem_we;
  logic [urif_pkg::ROW_AW-1:0] mem_waddr;
  logic [urif_pkg::ROW_AW-1:0] mem_raddr;
  logic [urif_pkg::ROW_W-1:0]  mem_wdata;
  logic [urif_pkg::ROW_W-1:0]  bit_mask;

  assign n_eff    = urif_pkg::effective_size(item_count);
  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign rem_sh   = {rem_r, div_word_r[urif_pkg::WORD_W-1]};
  assign rem_ge   = (rem_sh >= n_eff);
  assign rem_diff = rem_sh - n_eff;

  assign mem_raddr = rem_r[urif_pkg::IDX_W-1:urif_pkg::ROW_BITS];
  assign bit_mask  = urif_pkg::ROW_W'(1) << rem_r[urif_pkg::ROW_BITS-1:0];
  assign hit       = rd_data_r[rem_r[urif_pkg::ROW_BITS-1:0]];
  assign out_free  = !out_valid_r || !out_stall;

  // control outputs
  always_comb begin
    q_pop       = 1'b0;
    start_div   = 1'b0;
    start_clear = 1'b0;
    emit        = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = mem_raddr;
    mem_wdata   = rd_data_r | bit_mask;
    case (state_r)
      urif_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = row_cnt_r;
        mem_wdata = '0;
      end
      urif_pkg::ST_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          if (q_item.kind == urif_pkg::ITEM_RESTART) begin
            start_clear = 1'b1;
          end else if (filled_r < n_eff) begin
            start_div = 1'b1;
          end
        end
      end
      urif_pkg::ST_CHECK: begin
        emit   = !hit && out_free;
        mem_we = emit;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      urif_pkg::ST_CLEAR: begin
        if (row_cnt_r == urif_pkg::ROW_AW'(urif_pkg::ROWS - 1)) begin
          state_nxt = urif_pkg::ST_IDLE;
        end
      end
      urif_pkg::ST_IDLE: begin
        if (start_clear) begin
          state_nxt = urif_pkg::ST_CLEAR;
        end else if (start_div) begin
          state_nxt = urif_pkg::ST_DIV;
        end
      end
      urif_pkg::ST_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = urif_pkg::ST_READ;
        end
      end
      urif_pkg::ST_READ: begin
        state_nxt = urif_pkg::ST_CHECK;
      end
      urif_pkg::ST_CHECK: begin
        if (hit || out_free) begin
          state_nxt = urif_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = urif_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= urif_pkg::ST_CLEAR;
      row_cnt_r   <= '0;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start_clear) begin
        row_cnt_r <= '0;
      end else if (state_r == urif_pkg::ST_CLEAR) begin
        row_cnt_r <= row_cnt_r + urif_pkg::ROW_AW'(1);
      end
      if (start_clear) begin
        filled_r <= '0;
      end else if (emit) begin
        filled_r <= filled_r + urif_pkg::CNT_W'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (start_div) begin
      rem_r      <= '0;
      div_word_r <= q_item.word;
      div_cnt_r  <= urif_pkg::DIV_CW'(urif_pkg::WORD_W - 1);
    end else if (state_r == urif_pkg::ST_DIV) begin
      rem_r      <= rem_ge ? rem_diff[urif_pkg::IDX_W-1:0] : rem_sh[urif_pkg::IDX_W-1:0];
      div_word_r <= div_word_r << 1;
      div_cnt_r  <= div_cnt_r - urif_pkg::DIV_CW'(1);
    end
  end

  // bitmap, one row of 32 flags per word
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= map_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index_r    <= urif_pkg::OUT_W'(rem_r);
      out_position_r <= filled_r[urif_pkg::OUT_W-1:0];
      out_last_r     <= (urif_pkg::CNT_W'(filled_r + urif_pkg::CNT_W'(1)) == n_eff);
    end
  end

  assign status.clearing = (state_r == urif_pkg::ST_CLEAR);
  assign out_valid       = out_valid_r;
  assign out_index_value = out_index_r;
  assign out_position    = out_position_r;
  assign out_last        = out_last_r;

endmodule

### rtl/unique_random_index_filter_top.sv
// Top level of the unique random index filter.
// Depends on urif_pkg, urif_front, urif_queue and urif_back.
//
// Produces a random permutation of 0..N-1 by rejection sampling. Each input
// transfer is either an offer (command 0) carrying a 30-bit random word, or a
// restart (command 1). An offer is reduced modulo N, the configured
// item_count (zero acts as 1, values above 65536 as 65536), and looked up in
// a visited bitmap; a fresh index is marked and sent out with its zero-based
// position, and last is set on the N-th one. Repeats, and offers arriving
// once all N are filled, give no output transfer. A restart clears the
// bitmap and the fill count and gives no output.
// An offer passes through the back end in steps: it is taken from the
// queue, its remainder is formed bit-serially (one dividend bit per cycle),
// the bitmap row is read, then it is checked and written. Offers dropped
// because the permutation is complete are discarded when taken from the
// queue. The bitmap is 2048 rows of 32 flags; after reset and after each
// restart a sweep clears one row a cycle, with in_stall held high. A
// two-entry queue sits between the input register and the back end, and
// the output register lets a finished result wait on out_stall while the
// next offer is worked on. item_count is written through
// cfg_wr_en/cfg_wr_data and should only be changed while the block is idle.
module unique_random_index_filter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [urif_pkg::CNT_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [urif_pkg::WORD_W-1:0]  in_random_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [urif_pkg::OUT_W-1:0]   out_index_value,
  output logic [urif_pkg::OUT_W-1:0]   out_position,
  output logic                         out_last
);

  logic [urif_pkg::CNT_W-1:0] item_count_r;
  urif_pkg::back_status_t     status;
  logic                       q_full, q_push, q_pop, q_valid;
  urif_pkg::item_t            q_push_item;
  urif_pkg::item_t            q_item;

  // size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= urif_pkg::ITEM_COUNT_RESET;
    end else if (cfg_wr_en) begin
      item_count_r <= cfg_wr_data;
    end
  end

  urif_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_random_word (in_random_word),
    .status         (status),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_push_item    (q_push_item)
  );

  urif_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .item      (q_item)
  );

  urif_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_count      (item_count_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_index_value (out_index_value),
    .out_position    (out_position),
    .out_last        (out_last)
  );

endmodule

### rtl/urif_checker.sv
// Port-level checks for the unique random index filter, bound to the top level.
// Depends on urif_pkg and unique_random_index_filter_top.
module urif_port_checks (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         cfg_wr_en,
  input logic [urif_pkg::CNT_W-1:0]   cfg_wr_data,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_command,
  input logic [urif_pkg::WORD_W-1:0]  in_random_word,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [urif_pkg::OUT_W-1:0]   out_index_value,
  input logic [urif_pkg::OUT_W-1:0]   out_position,
  input logic                         out_last
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_index_value)
      && $stable(out_position) && $stable(out_last))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_no_result: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result present straight after reset");

  // bitmap sweep follows reset, no intake meanwhile
  a_sweep_after_reset: assert property (@(posedge clk)
    $past(!rst_n) ##1 rst_n |-> in_stall)
    else $error("input taken during post-reset sweep");

endmodule

bind unique_random_index_filter_top urif_port_checks u_checker (.*);
